### src/dssc_pkg.sv
// ----------------------------------------------------------------------------
// Display subset support cache package
// Shared constants, codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dssc_pkg;

	// Fixed sizes of the path and subset fields.
	localparam int MAX_PATHS  = 8;
	localparam int MAX_SUBSET = 6;
	localparam int PW         = 3;   // path and slot number width
	localparam int CNT_W      = 4;   // width of counts up to MAX_PATHS
	localparam int IDX_W      = 9;   // width of a combinatorial subset index
	localparam int EPOCH_W    = 4;   // store generation mark width

	// Request functions.
	typedef enum logic [1:0] {
		FN_CONNECT = 2'd0,
		FN_QUERY   = 2'd1,
		FN_RECORD  = 2'd2,
		FN_INVAL   = 2'd3
	} func_t;

	// Query answers and stored codes.
	localparam logic [1:0] QR_UNKNOWN = 2'h0;
	localparam logic [1:0] QR_NOT_SUP = 2'h1;
	localparam logic [1:0] QR_SUP     = 2'h2;
	localparam logic [1:0] QR_INVALID = 2'h3;

	// Configuration register indexes.
	localparam logic REG_PATH_COUNT   = 1'b0;
	localparam logic REG_MAX_TOGETHER = 1'b1;

	// Binomial coefficients C(n,k) for n and k up to MAX_PATHS.
	localparam logic [7:0] PASCAL [0:8][0:8] = '{
		'{8'd1, 8'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
		'{8'd1, 8'd1, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
		'{8'd1, 8'd2, 8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
		'{8'd1, 8'd3, 8'd3,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
		'{8'd1, 8'd4, 8'd6,  8'd4,  8'd1,  8'd0,  8'd0,  8'd0, 8'd0},
		'{8'd1, 8'd5, 8'd10, 8'd10, 8'd5,  8'd1,  8'd0,  8'd0, 8'd0},
		'{8'd1, 8'd6, 8'd15, 8'd20, 8'd15, 8'd6,  8'd1,  8'd0, 8'd0},
		'{8'd1, 8'd7, 8'd21, 8'd35, 8'd35, 8'd21, 8'd7,  8'd1, 8'd0},
		'{8'd1, 8'd8, 8'd28, 8'd56, 8'd70, 8'd56, 8'd28, 8'd8, 8'd1}
	};

	// C(n,k), zero where k exceeds n or n lies beyond the table.
	function automatic logic [7:0] choose(input logic [CNT_W-1:0] n,
	                                      input logic [CNT_W-1:0] k);
		logic [7:0] r;
		r = 8'd0;
		if (n <= CNT_W'(MAX_PATHS) && k <= n) begin
			r = PASCAL[n][k];
		end
		return r;
	endfunction

	// Number of set bits in a path mask.
	function automatic logic [CNT_W-1:0] popcount(input logic [MAX_PATHS-1:0] m);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_PATHS; i++) begin
			c = c + CNT_W'(m[i]);
		end
		return c;
	endfunction

	// Number of subset codes for the given path count and largest subset.
	function automatic logic [IDX_W-1:0] code_total(input logic [CNT_W-1:0] pc,
	                                                input logic [2:0] mt);
		logic [IDX_W-1:0] s;
		s = '0;
		for (int i = 1; i <= MAX_PATHS; i++) begin
			if (CNT_W'(i) <= {1'b0, mt} && CNT_W'(i) <= pc) begin
				s = s + IDX_W'(choose(pc, CNT_W'(i)));
			end
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### src/dssc_code_store.sv
// ----------------------------------------------------------------------------
// Subset code store
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dssc_code_store #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 6
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### src/display_subset_support_cache_unit.sv
// ----------------------------------------------------------------------------
// Display subset support cache
// Records whether subsets of display paths can be enabled together.
// ----------------------------------------------------------------------------
// Requests enter on the req channel (req_valid, req_stall) and each one gives
// exactly one response on the rsp channel (rsp_valid, rsp_stall). One request
// is worked on at a time; req_stall is high while it is in progress.
// A request settled in its first step passes from acceptance through S_EVAL
// to S_DONE (via S_SWEEP when a clear wraps the mark), which loads the response
// register and returns to S_IDLE. This covers connection changes, invalidates,
// rejected requests, single-path and shortcut answers, and subsets with an unmapped path.
// Any other query or record walks the eight slot numbers one per cycle to
// build the combinatorial index, then reads the code memory unless the index
// lies past the store. It passes through S_EVAL, S_INDEX, S_CHECK, S_MERGE
// (skipped past the store) and S_DONE before the next request is taken.
// Clearing the code store bumps a 4-bit generation mark; every 16th clear
// instead sweeps all CODE_DEPTH entries of the memory.
// After reset the block sweeps the whole code memory before it takes its
// first request; configuration writes are taken at any time.
// A finished response waits in the output register while rsp_stall is high;
// the next request is accepted meanwhile and stops only when its own
// response is ready and the register is still full.
// The APB port holds path_count at address 0 and max_together at address 4.
// ----------------------------------------------------------------------------
`default_nettype none

module display_subset_support_cache_unit import dssc_pkg::*; #(
	parameter int CODE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  path_index,
	input  wire logic        is_connected,
	input  wire logic [7:0]  display_mask,
	input  wire logic        is_supported,
	input  wire logic        clear_singles,
	// Response channel.
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [1:0]       query_result,
	output logic             bad_request,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW = $clog2(CODE_DEPTH);
	localparam int MW = EPOCH_W + 2;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EVAL  = 7'b0000010,
		S_INDEX = 7'b0000100,
		S_CHECK = 7'b0001000,
		S_MERGE = 7'b0010000,
		S_SWEEP = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CNT_W-1:0] pc_q;
	logic [2:0]       mt_q;
	logic [IDX_W-1:0] cc_q;

	// Cache state.
	logic [MAX_PATHS-1:0] cm_q;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     slots_q;
	logic [PW-1:0]        p2s_q [MAX_PATHS];
	logic [MAX_PATHS-1:0] pmap_q;
	logic [PW-1:0]        s2p_q [MAX_PATHS];
	logic [MAX_PATHS-1:0] smap_q;
	logic [MAX_PATHS-1:0] sv_q;
	logic [MAX_PATHS-1:0] ss_q;
	logic [1:0]           acc_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [AW-1:0]        sweep_q;
	logic                 item_q;

	// Request registers.
	func_t                func_s1;
	logic [PW-1:0]        path_s1;
	logic                 conn_s1;
	logic [MAX_PATHS-1:0] mask_s1;
	logic                 sup_s1;
	logic                 clr_s1;

	// Index walk.
	logic [MAX_PATHS-1:0] slotv_q;
	logic [CNT_W-1:0]     size_q;
	logic [PW-1:0]        step_q;
	logic [CNT_W-1:0]     ord_q;
	logic [IDX_W-1:0]     idx_q;

	// Response.
	logic [1:0] res_q;
	logic       bad_q;
	logic       rsp_valid_q;
	logic [1:0] rsp_res_q;
	logic       rsp_bad_q;

	// Memory port.
	logic          mem_rd_en;
	logic [MW-1:0] mem_rd_data;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [MW-1:0] mem_wr_data;

	// Evaluation terms.
	logic [MAX_PATHS-1:0] bit_p;
	logic [MAX_PATHS-1:0] cm_new;
	logic [CNT_W-1:0]     tot_new;
	logic                 grow;
	logic [CNT_W-1:0]     slots_new;
	logic                 found;
	logic [PW-1:0]        fslot;
	logic                 path_bad;
	logic                 mask_bad;
	logic                 changed;
	logic [CNT_W-1:0]     size;
	logic                 sub_ok;
	logic                 map_ok;
	logic                 shortcut;
	logic [MAX_PATHS-1:0] slot_vec;
	logic                 clr_store;
	logic [IDX_W-1:0]     add1;
	logic [IDX_W-1:0]     add2;
	logic                 take;
	logic                 hit;
	logic [1:0]           cur_code;
	logic [1:0]           new_code;
	logic                 out_free;
	logic                 cfg_wr;
	logic [3:0]           pc_wr;
	logic [2:0]           mt_wr;

	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign pready    = 1'b1;

	// Configuration decode with clamping.
	always_comb begin
		cfg_wr = psel && penable && pwrite;
		pc_wr  = pwdata[3:0];
		if (pc_wr < 4'd1) begin
			pc_wr = 4'd1;
		end
		if (pc_wr > CNT_W'(MAX_PATHS)) begin
			pc_wr = CNT_W'(MAX_PATHS);
		end
		mt_wr = pwdata[2:0];
		if (mt_wr < 3'd1) begin
			mt_wr = 3'd1;
		end
		if (mt_wr > 3'(MAX_SUBSET)) begin
			mt_wr = 3'(MAX_SUBSET);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= CNT_W'(MAX_PATHS);
			mt_q <= 3'(MAX_SUBSET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PATH_COUNT:   pc_q <= pc_wr;
				REG_MAX_TOGETHER: mt_q <= mt_wr;
				default:          pc_q <= pc_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[2])
			REG_PATH_COUNT:   prdata = {28'd0, pc_q};
			REG_MAX_TOGETHER: prdata = {29'd0, mt_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Code count, limited to the store depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= '0;
		end else if (int'(code_total(pc_q, mt_q)) > CODE_DEPTH) begin
			cc_q <= IDX_W'(CODE_DEPTH);
		end else begin
			cc_q <= code_total(pc_q, mt_q);
		end
	end

	// Connection, mask and shortcut terms of the held request.
	always_comb begin
		bit_p     = MAX_PATHS'(1) << path_s1;
		cm_new    = conn_s1 ? (cm_q | bit_p) : (cm_q & ~bit_p);
		tot_new   = conn_s1 ? total_q + 1'b1 : total_q - 1'b1;
		grow      = (tot_new > slots_q) && (slots_q < CNT_W'(MAX_PATHS));
		slots_new = slots_q + CNT_W'(grow);
		found     = 1'b0;
		fslot     = '0;
		for (int i = 0; i < MAX_PATHS; i++) begin
			if (!found && CNT_W'(i) < slots_new) begin
				if (!smap_q[i] || !cm_new[s2p_q[i]]) begin
					found = 1'b1;
					fslot = PW'(i);
				end
			end
		end
		path_bad = {1'b0, path_s1} >= pc_q;
		changed  = cm_q[path_s1] != conn_s1;
		mask_bad = (mask_s1 == '0) || ((mask_s1 >> pc_q) != '0);
		size     = popcount(mask_s1);
		sub_ok   = (mask_s1 & ~cm_q) == '0;
		map_ok   = (mask_s1 & ~pmap_q) == '0;
		shortcut = (size <= total_q) && (size <= {1'b0, mt_q}) &&
		           (acc_q != QR_UNKNOWN) && sub_ok;
		slot_vec = '0;
		for (int p = 0; p < MAX_PATHS; p++) begin
			if (mask_s1[p]) begin
				slot_vec[p2s_q[p]] = 1'b1;
			end
		end
		clr_store = 1'b0;
		if (state_q == S_EVAL) begin
			if (func_s1 == FN_INVAL) begin
				clr_store = 1'b1;
			end else if (func_s1 == FN_CONNECT && !path_bad && changed) begin
				clr_store = grow || (conn_s1 && !pmap_q[path_s1]);
			end
		end
	end

	// One step of the combinatorial index walk.
	always_comb begin
		add1 = '0;
		if (step_q != '0 && {1'b0, step_q} < size_q) begin
			add1 = IDX_W'(choose(slots_q, {1'b0, step_q}));
		end
		take = slotv_q[step_q] && (ord_q < size_q);
		add2 = take ? IDX_W'(choose({1'b0, step_q}, ord_q + 1'b1)) : '0;
	end

	// Merge of the stored code with the current generation.
	always_comb begin
		hit      = mem_rd_data[MW-1:2] == epoch_q;
		cur_code = hit ? mem_rd_data[1:0] : QR_UNKNOWN;
		new_code = cur_code | (sup_s1 ? QR_SUP : QR_NOT_SUP);
	end

	// Memory port control.
	always_comb begin
		mem_rd_en   = (state_q == S_CHECK) && (idx_q < cc_q);
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(idx_q);
		mem_wr_data = {epoch_q, new_code};
		if (state_q == S_SWEEP) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = sweep_q;
			mem_wr_data = '0;
		end else if (state_q == S_MERGE && func_s1 == FN_RECORD) begin
			mem_wr_en = 1'b1;
		end
	end

	dssc_code_store #(
		.DEPTH (CODE_DEPTH),
		.WIDTH (MW)
	) u_store (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (AW'(idx_q)),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// Request sequencer and cache state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			item_q  <= 1'b0;
			sweep_q <= '0;
			epoch_q <= '0;
			cm_q    <= '0;
			total_q <= '0;
			slots_q <= '0;
			pmap_q  <= '0;
			smap_q  <= '0;
			sv_q    <= '0;
			ss_q    <= '0;
			acc_q   <= QR_UNKNOWN;
			for (int i = 0; i < MAX_PATHS; i++) begin
				p2s_q[i] <= '0;
				s2p_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_s1 <= func_t'(func);
						path_s1 <= path_index;
						conn_s1 <= is_connected;
						mask_s1 <= display_mask;
						sup_s1  <= is_supported;
						clr_s1  <= clear_singles;
						res_q   <= QR_UNKNOWN;
						bad_q   <= 1'b0;
						item_q  <= 1'b1;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_DONE;
					step_q  <= '0;
					ord_q   <= '0;
					idx_q   <= '0;
					slotv_q <= slot_vec;
					size_q  <= size;
					unique case (func_s1)
						FN_CONNECT: begin
							if (path_bad) begin
								bad_q <= 1'b1;
							end else if (changed) begin
								cm_q    <= cm_new;
								total_q <= tot_new;
								slots_q <= slots_new;
								if (!conn_s1) begin
									if (acc_q == QR_NOT_SUP) begin
										acc_q <= QR_UNKNOWN;
									end
								end else if (pmap_q[path_s1]) begin
									if (acc_q == QR_SUP) begin
										acc_q <= QR_UNKNOWN;
									end
								end else begin
									acc_q <= QR_UNKNOWN;
									if (found) begin
										if (smap_q[fslot]) begin
											pmap_q[s2p_q[fslot]] <= 1'b0;
											p2s_q[s2p_q[fslot]]  <= '0;
										end
										smap_q[fslot]   <= 1'b1;
										s2p_q[fslot]    <= path_s1;
										pmap_q[path_s1] <= 1'b1;
										p2s_q[path_s1]  <= fslot;
									end
								end
							end
						end
						FN_QUERY: begin
							if (mask_bad) begin
								bad_q <= 1'b1;
								res_q <= QR_INVALID;
							end else if (size == CNT_W'(1)) begin
								if ((sv_q & mask_s1) == '0) begin
									res_q <= QR_UNKNOWN;
								end else if ((ss_q & mask_s1) != '0) begin
									res_q <= QR_SUP;
								end else begin
									res_q <= QR_NOT_SUP;
								end
							end else if (shortcut && acc_q == QR_SUP) begin
								res_q <= QR_SUP;
							end else if (shortcut && size == total_q) begin
								res_q <= QR_NOT_SUP;
							end else if (!map_ok) begin
								res_q <= QR_INVALID;
							end else begin
								state_q <= S_INDEX;
							end
						end
						FN_RECORD: begin
							if (mask_bad) begin
								bad_q <= 1'b1;
							end else if (size == CNT_W'(1)) begin
								sv_q <= sv_q | mask_s1;
								if (sup_s1) begin
									ss_q <= ss_q | mask_s1;
								end
							end else begin
								if (sub_ok && size == total_q) begin
									acc_q <= sup_s1 ? QR_SUP : QR_NOT_SUP;
								end
								if (map_ok) begin
									state_q <= S_INDEX;
								end
							end
						end
						FN_INVAL: begin
							acc_q <= QR_UNKNOWN;
							if (clr_s1) begin
								sv_q <= '0;
								ss_q <= '0;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
					// A store clear bumps the generation, or sweeps on wrap.
					if (clr_store) begin
						if (epoch_q == '1) begin
							epoch_q <= '0;
							sweep_q <= '0;
							state_q <= S_SWEEP;
						end else begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
				end
				S_INDEX: begin
					idx_q  <= idx_q + add1 + add2;
					ord_q  <= ord_q + CNT_W'(take);
					step_q <= step_q + 1'b1;
					if (step_q == PW'(MAX_PATHS - 1)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (idx_q >= cc_q) begin
						if (func_s1 == FN_QUERY) begin
							res_q <= (size_q > {1'b0, mt_q}) ? QR_NOT_SUP : QR_INVALID;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (func_s1 == FN_QUERY) begin
						res_q <= cur_code;
					end
					state_q <= S_DONE;
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(CODE_DEPTH - 1)) begin
						state_q <= item_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						item_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_res_q <= res_q;
			rsp_bad_q <= bad_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign query_result = rsp_res_q;
	assign bad_request  = rsp_bad_q;

endmodule

`default_nettype wire

### tb/dssc_checker.sv
// ----------------------------------------------------------------------------
// Display subset support cache checker
// Watches the request, response and configuration ports, predicts each
// response from its own model of the cache and compares field by field.
// ----------------------------------------------------------------------------
module dssc_checker import dssc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  path_index,
	input  wire logic        is_connected,
	input  wire logic [7:0]  display_mask,
	input  wire logic        is_supported,
	input  wire logic        clear_singles,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire logic [1:0]  query_result,
	input  wire logic        bad_request,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] answer;
		logic       rejected;
	} answer_t;

	answer_t answers_due[$];

	// Shadow of the registers and of the cache state.
	int unsigned pc, mt;
	logic [7:0]  conn_mask;
	int unsigned conn_total, slots;
	int unsigned p2s [8];
	int unsigned s2p [8];
	bit          pmapped [8];
	bit          smapped [8];
	logic [1:0]  codes [256];
	logic [7:0]  single_valid, single_sup;
	logic [1:0]  all_code;

	assign outstanding = answers_due.size();

	function automatic int unsigned binom(int unsigned n, int unsigned k);
		int unsigned r;
		r = 1;
		if (n > MAX_PATHS || k > n) return 0;
		for (int unsigned i = 0; i < k; i++) r = r * (n - i) / (i + 1);
		return r;
	endfunction

	function automatic int unsigned ones(logic [7:0] m);
		int unsigned c;
		c = 0;
		for (int i = 0; i < 8; i++) c += m[i];
		return c;
	endfunction

	function automatic int unsigned store_size();
		int unsigned s;
		s = 0;
		for (int unsigned i = 1; i <= mt && i <= pc; i++) s += binom(pc, i);
		return s > 256 ? 256 : s;
	endfunction

	function automatic void wipe_codes();
		foreach (codes[i]) codes[i] = QR_UNKNOWN;
	endfunction

	function automatic bit all_mapped(logic [7:0] m);
		for (int p = 0; p < 8; p++)
			if (m[p] && !pmapped[p]) return 0;
		return 1;
	endfunction

	// Combinatorial number of the subset over the compact slot numbers.
	function automatic int unsigned comb_index(logic [7:0] m, int unsigned size);
		int unsigned idx, order;
		logic [15:0] used;
		idx = 0;
		order = 0;
		used = '0;
		for (int unsigned i = 1; i < size; i++) idx += binom(slots, i);
		for (int p = 0; p < 8; p++)
			if (m[p]) used[p2s[p] & 15] = 1'b1;
		for (int unsigned s = 0; s < 16 && order < size; s++) begin
			if (used[s]) begin
				idx += binom(s, order + 1);
				order++;
			end
		end
		return idx;
	endfunction

	function automatic void apply_connect(int unsigned p, logic c);
		if (conn_mask[p] == c) return;
		conn_mask[p] = c;
		if (c) conn_total++;
		else conn_total--;
		if (conn_total > slots && slots < MAX_PATHS) begin
			slots++;
			wipe_codes();
		end
		if (!c) begin
			if (all_code == QR_NOT_SUP) all_code = QR_UNKNOWN;
			return;
		end
		if (pmapped[p]) begin
			if (all_code == QR_SUP) all_code = QR_UNKNOWN;
			return;
		end
		for (int unsigned i = 0; i < slots && i < MAX_PATHS; i++) begin
			if (!smapped[i]) begin
				smapped[i] = 1;
				s2p[i] = p;
				pmapped[p] = 1;
				p2s[p] = i;
				break;
			end
			if (!conn_mask[s2p[i] % 8]) begin
				pmapped[s2p[i] % 8] = 0;
				p2s[s2p[i] % 8] = 0;
				s2p[i] = p;
				pmapped[p] = 1;
				p2s[p] = i;
				break;
			end
		end
		wipe_codes();
		all_code = QR_UNKNOWN;
	endfunction

	function automatic logic [1:0] lookup(logic [7:0] m);
		int unsigned size, idx;
		size = ones(m);
		if (size == 1) begin
			if ((single_valid & m) == 0) return QR_UNKNOWN;
			return ((single_sup & m) != 0) ? QR_SUP : QR_NOT_SUP;
		end
		if (size <= conn_total && size <= mt && all_code != QR_UNKNOWN &&
		    (m & ~conn_mask) == 0) begin
			if (all_code == QR_SUP) return QR_SUP;
			if (size == conn_total) return QR_NOT_SUP;
		end
		if (!all_mapped(m)) return QR_INVALID;
		idx = comb_index(m, size);
		if (idx >= store_size()) return size > mt ? QR_NOT_SUP : QR_INVALID;
		return codes[idx];
	endfunction

	function automatic void record(logic [7:0] m, logic sup);
		int unsigned size, idx;
		size = ones(m);
		if (size == 1) begin
			single_valid |= m;
			if (sup) single_sup |= m;
			return;
		end
		if ((m & ~conn_mask) == 0 && size == conn_total)
			all_code = sup ? QR_SUP : QR_NOT_SUP;
		if (!all_mapped(m)) return;
		idx = comb_index(m, size);
		if (idx >= store_size()) return;
		codes[idx] |= sup ? QR_SUP : QR_NOT_SUP;
	endfunction

	// Works out the response of one request and advances the shadow state.
	function automatic answer_t predict_answer();
		answer_t a;
		logic mask_bad;
		a = '0;
		mask_bad = display_mask == 0 || (display_mask >> pc) != 0;
		case (func_t'(func))
			FN_CONNECT: begin
				if (path_index >= pc) a.rejected = 1'b1;
				else apply_connect(path_index, is_connected);
			end
			FN_QUERY: begin
				if (mask_bad) begin
					a.rejected = 1'b1;
					a.answer = QR_INVALID;
				end else begin
					a.answer = lookup(display_mask);
				end
			end
			FN_RECORD: begin
				if (mask_bad) a.rejected = 1'b1;
				else record(display_mask, is_supported);
			end
			default: begin
				wipe_codes();
				all_code = QR_UNKNOWN;
				if (clear_singles) begin
					single_valid = '0;
					single_sup = '0;
				end
			end
		endcase
		return a;
	endfunction

	// Tracks register writes, request transactions and response transactions.
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		logic [31:0] v;
		if (!arst_n) begin
			pc = 8;
			mt = 6;
			conn_mask = '0;
			conn_total = 0;
			slots = 0;
			foreach (p2s[i]) begin
				p2s[i] = 0;
				s2p[i] = 0;
				pmapped[i] = 0;
				smapped[i] = 0;
			end
			wipe_codes();
			single_valid = '0;
			single_sup = '0;
			all_code = QR_UNKNOWN;
			errors = 0;
			answers_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_PATH_COUNT) begin
					v = pwdata & 32'hF;
					pc = v < 1 ? 1 : (v > MAX_PATHS ? MAX_PATHS : v);
				end else begin
					v = pwdata & 32'h7;
					mt = v < 1 ? 1 : (v > MAX_SUBSET ? MAX_SUBSET : v);
				end
			end
			if (req_valid && !req_stall) answers_due.push_back(predict_answer());
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					errors++;
					$display("%0t: response with none expected, actual %0d/%0d",
					         $realtime, query_result, bad_request);
				end else begin
					want = answers_due.pop_front();
					if (query_result !== want.answer) begin
						errors++;
						$display("%0t: query_result expected %0d actual %0d",
						         $realtime, want.answer, query_result);
					end
					if (bad_request !== want.rejected) begin
						errors++;
						$display("%0t: bad_request expected %0d actual %0d",
						         $realtime, want.rejected, bad_request);
					end
				end
			end
		end
	end
endmodule

### tb/tb_display_subset_support_cache_unit.sv
// ----------------------------------------------------------------------------
// Display subset support cache testbench
// Drives directed and random connection, query, record and invalidate
// requests through several register settings, with random gaps on the request
// channel and random stalls on the response channel, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_display_subset_support_cache_unit;
	import dssc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid, req_stall;
	logic [1:0]  func;
	logic [2:0]  path_index;
	logic        is_connected;
	logic [7:0]  display_mask;
	logic        is_supported, clear_singles;
	logic        rsp_valid, rsp_stall;
	logic [1:0]  query_result;
	logic        bad_request;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          errors, outstanding;

	// Stimulus controls and the sender's view of the connected paths.
	bit          calm = 0;
	bit          hold_rsp = 0;
	logic [7:0]  live_paths = '0;
	int unsigned cur_pc = 8;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	display_subset_support_cache_unit dut (.*);

	dssc_checker checker_i (.*);

	// Stalls the response channel in bursts, with one long hold-off on request.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_rsp = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offers one request and holds it until the transaction completes.
	task automatic issue(func_t f, logic [2:0] p, logic c, logic [7:0] m, logic s,
	                     logic clr);
		req_valid <= 1'b1;
		func <= f;
		path_index <= p;
		is_connected <= c;
		display_mask <= m;
		is_supported <= s;
		clear_singles <= clr;
		do @(posedge clk); while (req_stall);
		if (f == FN_CONNECT && p < cur_pc) live_paths[p] = c;
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly subsets of the connected paths, sometimes any mask at all.
	function automatic logic [7:0] pick_mask();
		logic [7:0] pool, m;
		pool = live_paths & 8'((1 << cur_pc) - 1);
		m = 8'($urandom);
		if (pool == 0 || $urandom_range(0, 6) == 0) return m;
		m &= pool;
		if (m == 0) m = pool;
		return m;
	endfunction

	task automatic random_request();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 22)
			issue(FN_CONNECT, 3'($urandom_range(0, 7)), 1'($urandom), 8'($urandom),
			      1'($urandom), 1'($urandom));
		else if (r < 58)
			issue(FN_QUERY, 3'($urandom), 1'($urandom), pick_mask(), 1'($urandom),
			      1'($urandom));
		else if (r < 94)
			issue(FN_RECORD, 3'($urandom), 1'($urandom), pick_mask(), 1'($urandom),
			      1'($urandom));
		else
			issue(FN_INVAL, 3'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
			      1'($urandom));
	endtask

	initial begin
		static logic [3:0] pc_set [7] = '{4'd8, 4'd1, 4'd4, 4'd0, 4'd15, 4'd3, 4'd8};
		static logic [2:0] mt_set [7] = '{3'd6, 3'd1, 3'd2, 3'd7, 3'd3, 3'd0, 3'd6};
		req_valid <= 1'b0;
		func <= FN_CONNECT;
		path_index <= '0;
		is_connected <= 1'b0;
		display_mask <= '0;
		is_supported <= 1'b0;
		clear_singles <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: boundaries, every function and the special cases.
		issue(FN_QUERY, 3'd0, 1'b0, 8'h03, 1'b0, 1'b0);
		issue(FN_CONNECT, 3'd0, 1'b1, 8'h00, 1'b0, 1'b0);
		issue(FN_CONNECT, 3'd1, 1'b1, 8'h00, 1'b0, 1'b0);
		issue(FN_CONNECT, 3'd7, 1'b1, 8'h00, 1'b0, 1'b0);
		issue(FN_CONNECT, 3'd7, 1'b1, 8'h00, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0);
		issue(FN_RECORD, 3'd0, 1'b0, 8'h00, 1'b1, 1'b0);
		issue(FN_RECORD, 3'd0, 1'b0, 8'h03, 1'b1, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h03, 1'b0, 1'b0);
		issue(FN_RECORD, 3'd0, 1'b0, 8'h83, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h83, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h81, 1'b0, 1'b0);
		issue(FN_RECORD, 3'd0, 1'b0, 8'h80, 1'b1, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h80, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h30, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'hFF, 1'b0, 1'b0);
		issue(FN_CONNECT, 3'd1, 1'b0, 8'h00, 1'b0, 1'b0);
		issue(FN_CONNECT, 3'd4, 1'b1, 8'h00, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h13, 1'b0, 1'b0);
		issue(FN_INVAL, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h80, 1'b0, 1'b0);
		issue(FN_INVAL, 3'd0, 1'b0, 8'h00, 1'b0, 1'b1);
		issue(FN_QUERY, 3'd0, 1'b0, 8'h80, 1'b0, 1'b0);
		drain();

		// Random phases, each under the register setting written for it.
		foreach (pc_set[ph]) begin
			write_reg(REG_PATH_COUNT, {$urandom} << 4 | pc_set[ph]);
			write_reg(REG_MAX_TOGETHER, {$urandom} << 3 | mt_set[ph]);
			cur_pc = pc_set[ph] == 0 ? 1 : (pc_set[ph] > 8 ? 8 : pc_set[ph]);
			calm = ph == 6;
			for (int n = 0; n < 220; n++) begin
				if (ph == 2 && n == 20) hold_rsp = 1;
				if (ph == 4 && n == 100) drain();
				random_request();
			end
			drain();
		end

		if (errors == 0) begin
			$display("** display_subset_support_cache_unit: PASSED **");
		end else begin
			$display("** display_subset_support_cache_unit: FAILED **");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5ms;
		$display("** display_subset_support_cache_unit: FAILED **");
		$finish;
	end
endmodule

### display_subset_support_cache_unit.f
src/dssc_pkg.sv
src/dssc_code_store.sv
src/display_subset_support_cache_unit.sv
tb/dssc_checker.sv
tb/tb_display_subset_support_cache_unit.sv
